[src/sgl_pkg.sv]
// ----------------------------------------------------------------------------
// sgl_pkg: shared types and constants of the gap list builder
// Holds the command codes, the list capacity, the serial comparison helper
// and the structs that pass state and results between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sgl_pkg;

	// Widths fixed by the item and result formats.
	localparam int unsigned SEQ_W   = 32;
	localparam int unsigned HOLES_W = 5;

	// Capacity of the hole list and the width of the counter that tracks it.
	localparam int unsigned MAX_HOLES = 16;
	localparam int unsigned CNT_W     = $clog2(MAX_HOLES + 1);

	// Command codes carried by an input beat.
	typedef enum logic [1:0] {
		CMD_START  = 2'd0,
		CMD_RECV   = 2'd1,
		CMD_FINISH = 2'd2
	} cmd_t;

	// Walk state kept between items.
	typedef struct packed {
		logic [SEQ_W-1:0] last_seen;
		logic [CNT_W-1:0] hole_cnt;
		logic [SEQ_W-1:0] highest;
	} walk_state_t;

	// One result beat.
	typedef struct packed {
		logic               hole_valid;
		logic [SEQ_W-1:0]   hole_first;
		logic [SEQ_W-1:0]   hole_len;
		logic [HOLES_W-1:0] holes_listed;
		logic [SEQ_W-1:0]   highest_index;
		logic               list_full;
	} result_t;

	// Serial number comparison: a is ahead of b when (a - b) mod 2^32 lies
	// in 1 .. 2^31 - 1.
	function automatic logic serial_ahead(input logic [SEQ_W-1:0] a,
	                                      input logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = a - b;
		return (d != '0) && !d[SEQ_W-1];
	endfunction

endpackage

`default_nettype wire

[src/sgl_gap_logic.sv]
// ----------------------------------------------------------------------------
// sgl_gap_logic: per-item hole detection
// Combinational step from the current walk state and one registered item to
// the next walk state and the result beat for that item.
// ----------------------------------------------------------------------------
`default_nettype none

module sgl_gap_logic (
	input  wire logic [1:0]                     cmd,
	input  wire logic [sgl_pkg::SEQ_W-1:0]      seq_index,
	input  wire logic [sgl_pkg::SEQ_W-1:0]      peer_count,
	input  wire sgl_pkg::walk_state_t           cur_state,
	output sgl_pkg::walk_state_t                next_state,
	output sgl_pkg::result_t                    result
);

	logic                        room;
	logic                        room_next;
	logic [sgl_pkg::SEQ_W-1:0]   need;
	logic [sgl_pkg::SEQ_W-1:0]   last_peer;
	logic                        hole;
	logic [sgl_pkg::SEQ_W-1:0]   first;
	logic [sgl_pkg::SEQ_W-1:0]   len;

	// Room remains while fewer holes than the capacity are listed.
	assign room      = cur_state.hole_cnt < sgl_pkg::CNT_W'(sgl_pkg::MAX_HOLES);
	assign need      = cur_state.last_seen + sgl_pkg::SEQ_W'(1);
	assign last_peer = seq_index + peer_count - sgl_pkg::SEQ_W'(1);

	// Decode the command and work out the next state.
	always_comb begin
		next_state = cur_state;
		hole       = 1'b0;
		first      = '0;
		len        = '0;
		case (cmd)
			sgl_pkg::CMD_START: begin
				next_state.last_seen = seq_index;
				next_state.hole_cnt  = '0;
			end
			sgl_pkg::CMD_RECV: begin
				if (room) begin
					next_state.last_seen = seq_index;
					if (sgl_pkg::serial_ahead(seq_index, cur_state.highest)) begin
						next_state.highest = seq_index;
					end
					if (sgl_pkg::serial_ahead(seq_index, need)) begin
						hole  = 1'b1;
						first = need;
						len   = seq_index - need;
					end
				end
			end
			sgl_pkg::CMD_FINISH: begin
				if ((peer_count != '0) && room &&
				    sgl_pkg::serial_ahead(last_peer, cur_state.last_seen)) begin
					hole  = 1'b1;
					first = need;
					len   = last_peer - cur_state.last_seen;
				end
			end
			default: begin
				// Unknown command: state and hole fields stay as they are.
			end
		endcase
		if (hole) begin
			next_state.hole_cnt = cur_state.hole_cnt + sgl_pkg::CNT_W'(1);
		end
	end

	// Status after this item.
	assign room_next = next_state.hole_cnt < sgl_pkg::CNT_W'(sgl_pkg::MAX_HOLES);

	always_comb begin
		result.hole_valid    = hole;
		result.hole_first    = first;
		result.hole_len      = len;
		result.holes_listed  = sgl_pkg::HOLES_W'(next_state.hole_cnt);
		result.highest_index = next_state.highest;
		result.list_full     = !room_next;
	end

endmodule

`default_nettype wire

[src/sequence_gap_list_builder.sv]
// ----------------------------------------------------------------------------
// sequence_gap_list_builder: gap list builder for retransmit requests
// Input register, hole detection logic and result register.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the item channel (item_valid, item_ready, with cmd,
// seq_index and peer_count). A start beat loads the last in-order index and
// empties the list, received beats walk the buffered chunk indices in order,
// and a finish beat carries the peer's first index and count for the tail.
// Every item gives exactly one result beat on the result channel
// (result_valid, result_ready) with hole_valid, hole_first, hole_len,
// holes_listed, highest_index and list_full.
// An accepted item waits in the input register until the result register
// is free or drains, and then loads into it. Throughput is one item per
// cycle while the receiver does not stall; the walk state is updated in the
// same cycle the result register loads, so the next item sees it without a bubble.
// When the receiver stalls, the result register holds its beat, the input
// register still takes one more item, and then item_ready drops.
// Reset clears both registers' valid flags and the walk state (last index,
// hole count and highest index) to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_gap_list_builder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           item_valid,
	output logic                                item_ready,
	input  wire logic [1:0]                     cmd,
	input  wire logic [sgl_pkg::SEQ_W-1:0]      seq_index,
	input  wire logic [sgl_pkg::SEQ_W-1:0]      peer_count,
	output logic                                result_valid,
	input  wire logic                           result_ready,
	output logic                                hole_valid,
	output logic [sgl_pkg::SEQ_W-1:0]           hole_first,
	output logic [sgl_pkg::SEQ_W-1:0]           hole_len,
	output logic [sgl_pkg::HOLES_W-1:0]         holes_listed,
	output logic [sgl_pkg::SEQ_W-1:0]           highest_index,
	output logic                                list_full
);

	logic                        valid_s1;
	logic [1:0]                  cmd_s1;
	logic [sgl_pkg::SEQ_W-1:0]   seq_s1;
	logic [sgl_pkg::SEQ_W-1:0]   cnt_s1;
	logic                        valid_s2;
	sgl_pkg::result_t            result_s2;
	sgl_pkg::walk_state_t        state_q;
	sgl_pkg::walk_state_t        state_next;
	sgl_pkg::result_t            result_next;
	logic                        advance;

	// The registered item moves on when the result register is free or drains.
	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign item_ready = !valid_s1 || advance;

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			cmd_s1 <= cmd;
			seq_s1 <= seq_index;
			cnt_s1 <= peer_count;
		end
	end

	sgl_gap_logic u_gap_logic (
		.cmd        (cmd_s1),
		.seq_index  (seq_s1),
		.peer_count (cnt_s1),
		.cur_state  (state_q),
		.next_state (state_next),
		.result     (result_next)
	);

	// Walk state follows each item as it leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_next;
		end
	end

	assign result_valid  = valid_s2;
	assign hole_valid    = result_s2.hole_valid;
	assign hole_first    = result_s2.hole_first;
	assign hole_len      = result_s2.hole_len;
	assign holes_listed  = result_s2.holes_listed;
	assign highest_index = result_s2.highest_index;
	assign list_full     = result_s2.list_full;

endmodule

`default_nettype wire

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the sequence gap list builder
// Drives start, received and finish beats, mostly as whole retransmit lists
// with random gaps, wraps and late indices, and mixes in unused commands and
// random noise. A scoreboard predicts every result beat from its own copy of
// the walk state and compares it field by field. Both channels stall at
// random, with one long stretch where they never stall.
// ----------------------------------------------------------------------------
module tb_top;

	localparam logic [1:0] CMD_UNUSED  = 2'd3;
	localparam int         ITEM_TARGET = 1550;
	localparam int         CYCLE_LIMIT = 200000;
	localparam int         DRAIN_WAIT  = 8;

	// Predicts the result of every accepted beat and checks the results.
	class gap_list_scoreboard;
		logic [sgl_pkg::SEQ_W-1:0] last_index;
		logic [sgl_pkg::SEQ_W-1:0] top_index;
		int unsigned               holes;
		sgl_pkg::result_t          expected_q[$];
		int unsigned               mismatches;

		function new();
			last_index = '0;
			top_index  = '0;
			holes      = 0;
			mismatches = 0;
		endfunction

		// True when a is ahead of b by serial number arithmetic.
		function bit is_later(logic [sgl_pkg::SEQ_W-1:0] a, logic [sgl_pkg::SEQ_W-1:0] b);
			logic [sgl_pkg::SEQ_W-1:0] d;
			d = a - b;
			return (d != '0) && (d < 32'h8000_0000);
		endfunction

		// Updates the walk state for one accepted beat and queues its result.
		function void note_item(logic [1:0] c, logic [sgl_pkg::SEQ_W-1:0] s,
			logic [sgl_pkg::SEQ_W-1:0] n);
			sgl_pkg::result_t          e;
			logic [sgl_pkg::SEQ_W-1:0] need;
			logic [sgl_pkg::SEQ_W-1:0] tail;
			e = '0;
			case (c)
				sgl_pkg::CMD_START: begin
					last_index = s;
					holes      = 0;
				end
				sgl_pkg::CMD_RECV: begin
					if (holes < sgl_pkg::MAX_HOLES) begin
						need       = last_index + 1;
						last_index = s;
						if (is_later(s, top_index))
							top_index = s;
						if (is_later(s, need)) begin
							e.hole_valid = 1'b1;
							e.hole_first = need;
							e.hole_len   = s - need;
							holes++;
						end
					end
				end
				sgl_pkg::CMD_FINISH: begin
					if (n != '0 && holes < sgl_pkg::MAX_HOLES) begin
						tail = s + n - 1;
						if (is_later(tail, last_index)) begin
							e.hole_valid = 1'b1;
							e.hole_first = last_index + 1;
							e.hole_len   = tail - last_index;
							holes++;
						end
					end
				end
				default: begin
				end
			endcase
			e.holes_listed  = holes[sgl_pkg::HOLES_W-1:0];
			e.highest_index = top_index;
			e.list_full     = (holes >= sgl_pkg::MAX_HOLES);
			expected_q.push_back(e);
		endfunction

		function void cmp_field(string field, logic [sgl_pkg::SEQ_W-1:0] want,
			logic [sgl_pkg::SEQ_W-1:0] got);
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch on %s: expected %h, actual %h", field, want, got);
			end
		endfunction

		// Compares one result beat with the oldest prediction.
		function void check_result(sgl_pkg::result_t got);
			sgl_pkg::result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result beat: %p", got);
				return;
			end
			want = expected_q.pop_front();
			cmp_field("hole_valid", 32'(want.hole_valid), 32'(got.hole_valid));
			cmp_field("hole_first", want.hole_first, got.hole_first);
			cmp_field("hole_len", want.hole_len, got.hole_len);
			cmp_field("holes_listed", 32'(want.holes_listed), 32'(got.holes_listed));
			cmp_field("highest_index", want.highest_index, got.highest_index);
			cmp_field("list_full", 32'(want.list_full), 32'(got.list_full));
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        item_valid   = 1'b0;
	logic                        item_ready;
	logic [1:0]                  cmd          = sgl_pkg::CMD_START;
	logic [sgl_pkg::SEQ_W-1:0]   seq_index    = '0;
	logic [sgl_pkg::SEQ_W-1:0]   peer_count   = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	logic                        hole_valid;
	logic [sgl_pkg::SEQ_W-1:0]   hole_first;
	logic [sgl_pkg::SEQ_W-1:0]   hole_len;
	logic [sgl_pkg::HOLES_W-1:0] holes_listed;
	logic [sgl_pkg::SEQ_W-1:0]   highest_index;
	logic                        list_full;

	gap_list_scoreboard board = new();
	bit                 steady = 1'b0;
	int                 walk_items = 0;
	int                 cycles = 0;

	sequence_gap_list_builder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.cmd          (cmd),
		.seq_index    (seq_index),
		.peer_count   (peer_count),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.hole_valid   (hole_valid),
		.hole_first   (hole_first),
		.hole_len     (hole_len),
		.holes_listed (holes_listed),
		.highest_index(highest_index),
		.list_full    (list_full)
	);

	always #6 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Result side: check each accepted beat, stall now and then.
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready)
			board.check_result(sgl_pkg::result_t'({hole_valid, hole_first, hole_len,
				holes_listed, highest_index, list_full}));
		result_ready <= steady || ($urandom_range(99) >= 10);
	end

	// Offers one beat, waits for it to be taken, then records it.
	task automatic push_item(input logic [1:0] c, input logic [sgl_pkg::SEQ_W-1:0] s,
		input logic [sgl_pkg::SEQ_W-1:0] n);
		if (!steady && $urandom_range(99) < 5) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		item_valid <= 1'b1;
		cmd        <= c;
		seq_index  <= s;
		peer_count <= n;
		do @(posedge clk); while (!item_ready);
		board.note_item(c, s, n);
		walk_items++;
	endtask

	// Holds the sender off until every predicted result has come back.
	task automatic drain();
		item_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
	endtask

	// Start index: often close to a wrap point so the walk crosses it.
	function automatic logic [sgl_pkg::SEQ_W-1:0] pick_base();
		int r;
		r = $urandom_range(99);
		if (r < 25)
			return 32'hFFFF_FFF0 + $urandom_range(15);
		else if (r < 35)
			return 32'h7FFF_FFF0 + $urandom_range(15);
		return $urandom;
	endfunction

	// One whole list: start, a walk of received indices, one or two finishes.
	task automatic run_list();
		logic [sgl_pkg::SEQ_W-1:0] base;
		logic [sgl_pkg::SEQ_W-1:0] cur;
		logic [sgl_pkg::SEQ_W-1:0] first;
		logic [sgl_pkg::SEQ_W-1:0] count;
		int                        len;
		int                        gap_pct;
		int                        r;
		base = pick_base();
		cur  = base;
		case ($urandom_range(3))
			0: gap_pct = 0;
			1: gap_pct = 25;
			2: gap_pct = 60;
			default: gap_pct = 95;
		endcase
		len = $urandom_range(24, 1);
		push_item(sgl_pkg::CMD_START, base, $urandom);
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(99);
			if (r < gap_pct)
				cur += ($urandom_range(9) == 0) ? $urandom : $urandom_range(40, 2);
			else if (r < gap_pct + 5)
				cur -= $urandom_range(5);
			else
				cur += 1;
			push_item(sgl_pkg::CMD_RECV, cur, $urandom);
		end
		first = base + 1;
		r = $urandom_range(99);
		if (r < 15)
			count = '0;
		else if (r < 30)
			count = $urandom;
		else
			count = cur + $urandom_range(10) - 3 - first + 1;
		push_item(sgl_pkg::CMD_FINISH, first, count);
		if ($urandom_range(4) == 0)
			push_item(sgl_pkg::CMD_FINISH, first, count + $urandom_range(5));
	endtask

	// Main stimulus.
	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: wraps, the exact half-range distance, late indices,
		// finishes with and without a tail, and the unused command.
		push_item(sgl_pkg::CMD_RECV, 32'd5, 32'd0);
		push_item(sgl_pkg::CMD_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(sgl_pkg::CMD_RECV, 32'h0000_0000, 32'd0);
		push_item(sgl_pkg::CMD_RECV, 32'h0000_0000, 32'd0);
		push_item(sgl_pkg::CMD_RECV, 32'h8000_0001, 32'd0);
		push_item(sgl_pkg::CMD_RECV, 32'h0000_0001, 32'd0);
		push_item(sgl_pkg::CMD_FINISH, 32'h0000_0000, 32'd0);
		push_item(sgl_pkg::CMD_FINISH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(sgl_pkg::CMD_FINISH, 32'h0000_0002, 32'd10);
		push_item(sgl_pkg::CMD_FINISH, 32'h0000_0002, 32'd10);
		push_item(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_item(sgl_pkg::CMD_START, 32'h0000_0000, 32'd0);
		push_item(sgl_pkg::CMD_RECV, 32'hFFFF_FFFF, 32'd0);
		push_item(sgl_pkg::CMD_FINISH, 32'h0000_0000, 32'd1);
		drain();

		// Random lists with some noise in between.
		while (walk_items < ITEM_TARGET) begin
			steady = (walk_items >= 500 && walk_items < 800);
			if ($urandom_range(9) == 0)
				push_item(2'($urandom_range(3)), $urandom, $urandom);
			else
				run_list();
			if ($urandom_range(19) == 0)
				drain();
		end
		steady = 1'b0;

		// Let the last results come out, then a few more cycles for strays.
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule

[files.f]
src/sgl_pkg.sv
src/sgl_gap_logic.sv
src/sequence_gap_list_builder.sv
tb/tb_top.sv
